>>> rtl/fls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fls_pkg
// Types and constants for the boiler fail-safe level supervisor.
// ----------------------------------------------------------------------------
package fls_pkg;

    // item kinds
    localparam logic [1:0] KIND_TICK     = 2'd0;
    localparam logic [1:0] KIND_TRIGGER  = 2'd1;
    localparam logic [1:0] KIND_RECOVERY = 2'd2;
    localparam logic [1:0] KIND_HEALTH   = 2'd3;

    // levels
    localparam logic [2:0] LVL_NORMAL    = 3'd0;
    localparam logic [2:0] LVL_WARNING   = 3'd1;
    localparam logic [2:0] LVL_DEGRADED  = 3'd2;
    localparam logic [2:0] LVL_CRITICAL  = 3'd3;
    localparam logic [2:0] LVL_EMERGENCY = 3'd4;
    localparam logic [2:0] LVL_SHUTDOWN  = 3'd5;

    // reasons
    localparam logic [2:0] RSN_NONE      = 3'd0;
    localparam logic [2:0] RSN_LOW_MEM   = 3'd1;
    localparam logic [2:0] RSN_SENS_READ = 3'd2;
    localparam logic [2:0] RSN_SENS_DATA = 3'd3;
    localparam logic [2:0] RSN_MODBUS    = 3'd4;
    localparam logic [2:0] RSN_OTHER     = 3'd5;

    // pump commands
    localparam logic [1:0] PUMP_NONE = 2'd0;
    localparam logic [1:0] PUMP_ON   = 2'd1;
    localparam logic [1:0] PUMP_OFF  = 2'd2;

    // status bit positions
    localparam int ST_WARN   = 0;
    localparam int ST_BERR   = 1;
    localparam int ST_ESTOP  = 2;
    localparam int ST_BOILER = 3;
    localparam int ST_RSTOP  = 4;

    // configuration register indexes
    localparam logic [2:0] CFG_RECOVERY_DELAY = 3'd0;
    localparam logic [2:0] CFG_MAX_ATTEMPTS   = 3'd1;
    localparam logic [2:0] CFG_HEAP_CRITICAL  = 3'd2;
    localparam logic [2:0] CFG_HEAP_WARNING   = 3'd3;
    localparam logic [2:0] CFG_HEAP_CLEAR_MIN = 3'd4;
    localparam logic [2:0] CFG_HEALTH_IVL     = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int HEAP_W     = 22;

    typedef struct packed {
        logic [1:0]        kind;
        logic [2:0]        req_level;
        logic [2:0]        req_reason;
        logic [HEAP_W-1:0] free_heap;
        logic              sensor_fault;
        logic              modbus_fault;
        logic              other_fault;
    } t_in;

    typedef struct packed {
        logic [2:0] level;
        logic       burner_shutdown;
        logic [1:0] pumps_cmd;
        logic       other_relays_off;
        logic       save_request;
        logic       warning_flag;
        logic       burner_error_flag;
        logic       emergency_stop_flag;
        logic       boiler_on_flag;
        logic       relay_stop_flag;
        logic       recovery_ok;
        logic [7:0] recovery_count;
    } t_out;

    // working state carried through the triggers of one item
    typedef struct packed {
        logic [2:0] level;
        logic [2:0] reason;
        logic [4:0] status;
        logic       taken;
        logic       burner;
        logic [1:0] pumps;
        logic       relays;
        logic       save;
    } t_work;

endpackage

`default_nettype wire

>>> rtl/failsafe_level_supervisor_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// failsafe_level_supervisor_top
// Boiler fail-safe level supervisor: level tracking, actions, recovery checks
// and interval-gated health checks, one item per beat.
// ----------------------------------------------------------------------------
// path: an input beat goes to the input register, then to the result
//   register, and is held there while the result side stalls
// throughput: one item per cycle while the result side does not stall; the
//   level update is a single combinational pass between the two registers
// reset: synchronous active low; level normal, boiler enabled, clock and
//   counters at zero, configuration at its defaults
module failsafe_level_supervisor_top #(
    parameter int TIME_BITS = 32
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire fls_pkg::t_in              i_in_data,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output fls_pkg::t_out                  o_out_data,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [fls_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [fls_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import fls_pkg::*;

    localparam int CMP_W = (TIME_BITS > CFG_DATA_W) ? TIME_BITS : CFG_DATA_W;

    // configuration
    logic [CFG_DATA_W-1:0] r_rec_delay;
    logic [7:0]            r_max_attempts;
    logic [HEAP_W-1:0]     r_heap_crit;
    logic [HEAP_W-1:0]     r_heap_warn;
    logic [HEAP_W-1:0]     r_heap_clear;
    logic [CFG_DATA_W-1:0] r_health_ivl;

    // state
    logic [2:0]           r_level;
    logic [2:0]           r_reason;
    logic [TIME_BITS-1:0] r_first_ms;
    logic                 r_first_valid;
    logic [7:0]           r_attempts;
    logic [TIME_BITS-1:0] r_now_ms;
    logic [TIME_BITS-1:0] r_last_check;
    logic [4:0]           r_status;

    // pipeline
    logic  r_in_valid;
    t_in   r_in;
    logic  r_out_valid;
    t_out  r_out;

    logic out_free;
    logic advance;

    t_work                w0, w1, w2, w3, n_work;
    logic [TIME_BITS-1:0] n_now_ms;
    logic [TIME_BITS-1:0] n_last_check;
    logic [7:0]           n_attempts;
    logic                 rec_ok;
    logic [TIME_BITS-1:0] rec_elapsed;
    logic [TIME_BITS-1:0] hc_elapsed;
    logic                 cause_ok;
    t_out                 n_out;

    function automatic t_work f_trigger(t_work s, logic [2:0] lvl_in, logic [2:0] rsn);
        t_work      r;
        logic [2:0] lvl;
        r   = s;
        lvl = (lvl_in > LVL_SHUTDOWN) ? LVL_SHUTDOWN : lvl_in;
        if (!(lvl <= s.level && s.level >= LVL_CRITICAL)) begin
            r.level  = lvl;
            r.reason = rsn;
            r.taken  = 1'b1;
            if (s.level < LVL_CRITICAL && lvl >= LVL_CRITICAL) r.save = 1'b1;
            if (lvl >= LVL_CRITICAL) r.burner = 1'b1;
            if (lvl >= LVL_EMERGENCY) r.pumps = PUMP_ON;
            case (lvl)
                LVL_NORMAL: begin
                    r.status[ST_WARN] = 1'b0;
                    r.status[ST_BERR] = 1'b0;
                end
                LVL_EMERGENCY: begin
                    r.relays            = 1'b1;
                    r.status[ST_ESTOP]  = 1'b1;
                    r.status[ST_BOILER] = 1'b0;
                end
                LVL_SHUTDOWN: begin
                    r.save   = 1'b1;
                    r.pumps  = PUMP_OFF;
                    r.relays = 1'b1;
                end
                default: ;
            endcase
            if (lvl >= LVL_WARNING) r.status[ST_BERR] = 1'b1;
            if (lvl == LVL_WARNING) r.status[ST_WARN] = 1'b1;
            if (lvl >= LVL_EMERGENCY) r.status[ST_RSTOP] = 1'b1;
        end
        return r;
    endfunction

    assign out_free    = !r_out_valid || !i_out_stall;
    assign advance     = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    assign rec_elapsed = r_now_ms - r_first_ms;
    assign hc_elapsed  = r_now_ms - r_last_check;

    always_comb begin
        w0          = '0;
        w0.level    = r_level;
        w0.reason   = r_reason;
        w0.status   = r_status;
        w1          = w0;
        w2          = w0;
        w3          = w0;
        n_work      = w0;
        n_now_ms    = r_now_ms;
        n_last_check = r_last_check;
        n_attempts  = r_attempts;
        rec_ok      = 1'b0;
        cause_ok    = 1'b1;
        case (r_in.kind)
            KIND_TICK: begin
                n_now_ms = r_now_ms + TIME_BITS'(1);
            end
            KIND_TRIGGER: begin
                n_work = f_trigger(w0, r_in.req_level, r_in.req_reason);
            end
            KIND_RECOVERY: begin
                if (r_level < LVL_CRITICAL) begin
                    rec_ok = 1'b1;
                end else if (r_attempts >= r_max_attempts) begin
                    rec_ok = 1'b0;
                end else if (CMP_W'(rec_elapsed) < CMP_W'(r_rec_delay)) begin
                    rec_ok = 1'b0;
                end else begin
                    if (r_attempts != 8'hFF) n_attempts = r_attempts + 8'd1;
                    if (r_reason == RSN_LOW_MEM && r_in.free_heap < r_heap_warn)
                        cause_ok = 1'b0;
                    if ((r_reason == RSN_SENS_READ || r_reason == RSN_SENS_DATA)
                        && r_in.sensor_fault)
                        cause_ok = 1'b0;
                    if (r_reason == RSN_MODBUS && r_in.modbus_fault) cause_ok = 1'b0;
                    rec_ok = cause_ok;
                    if (cause_ok) begin
                        n_work.status[ST_WARN]   = 1'b0;
                        n_work.status[ST_BERR]   = 1'b0;
                        n_work.status[ST_ESTOP]  = 1'b0;
                        n_work.status[ST_BOILER] = 1'b1;
                        n_work.level             = LVL_WARNING;
                    end
                end
            end
            default: begin
                if (!(CMP_W'(hc_elapsed) < CMP_W'(r_health_ivl))) begin
                    n_last_check = r_now_ms;
                    if (r_in.free_heap < r_heap_crit)
                        w1 = f_trigger(w0, LVL_CRITICAL, RSN_LOW_MEM);
                    else if (r_in.free_heap < r_heap_warn)
                        w1 = f_trigger(w0, LVL_WARNING, RSN_LOW_MEM);
                    else
                        w1 = w0;
                    w2 = r_in.sensor_fault ? f_trigger(w1, LVL_DEGRADED, RSN_SENS_READ) : w1;
                    w3 = r_in.modbus_fault ? f_trigger(w2, LVL_WARNING, RSN_MODBUS) : w2;
                    n_work = w3;
                    // all clear while in warning drops back to normal
                    if (w3.level == LVL_WARNING && !r_in.sensor_fault
                        && !r_in.modbus_fault && !r_in.other_fault
                        && r_in.free_heap > r_heap_clear) begin
                        n_work.level          = LVL_NORMAL;
                        n_work.status[ST_WARN] = 1'b0;
                        n_work.status[ST_BERR] = 1'b0;
                    end
                end
            end
        endcase

        n_out.level               = n_work.level;
        n_out.burner_shutdown     = n_work.burner;
        n_out.pumps_cmd           = n_work.pumps;
        n_out.other_relays_off    = n_work.relays;
        n_out.save_request        = n_work.save;
        n_out.warning_flag        = n_work.status[ST_WARN];
        n_out.burner_error_flag   = n_work.status[ST_BERR];
        n_out.emergency_stop_flag = n_work.status[ST_ESTOP];
        n_out.boiler_on_flag      = n_work.status[ST_BOILER];
        n_out.relay_stop_flag     = n_work.status[ST_RSTOP];
        n_out.recovery_ok         = rec_ok;
        n_out.recovery_count      = n_attempts;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    // supervisor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level       <= LVL_NORMAL;
            r_reason      <= RSN_NONE;
            r_first_ms    <= '0;
            r_first_valid <= 1'b0;
            r_attempts    <= '0;
            r_now_ms      <= '0;
            r_last_check  <= '0;
            r_status      <= 5'(1 << ST_BOILER);
        end else if (advance) begin
            r_level      <= n_work.level;
            r_reason     <= n_work.reason;
            r_status     <= n_work.status;
            r_attempts   <= n_attempts;
            r_now_ms     <= n_now_ms;
            r_last_check <= n_last_check;
            if (n_work.taken && !r_first_valid) begin
                r_first_valid <= 1'b1;
                r_first_ms    <= r_now_ms;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_delay    <= CFG_DATA_W'(30000);
            r_max_attempts <= 8'd3;
            r_heap_crit    <= HEAP_W'(10000);
            r_heap_warn    <= HEAP_W'(20000);
            r_heap_clear   <= HEAP_W'(30000);
            r_health_ivl   <= CFG_DATA_W'(5000);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RECOVERY_DELAY: r_rec_delay    <= i_cfg_data;
                CFG_MAX_ATTEMPTS:   r_max_attempts <= i_cfg_data[7:0];
                CFG_HEAP_CRITICAL:  r_heap_crit    <= i_cfg_data[HEAP_W-1:0];
                CFG_HEAP_WARNING:   r_heap_warn    <= i_cfg_data[HEAP_W-1:0];
                CFG_HEAP_CLEAR_MIN: r_heap_clear   <= i_cfg_data[HEAP_W-1:0];
                CFG_HEALTH_IVL:     r_health_ivl   <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> test/failsafe_level_supervisor_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// failsafe_level_supervisor_top_tb
// Drives ticks, triggers, recovery requests and health checks into the
// supervisor, predicts every result beat in the bench and compares it with
// the block. Stalls on both sides, a long result hold-off, and a series of
// limit settings that includes the extremes.
// ----------------------------------------------------------------------------
module failsafe_level_supervisor_top_tb;
    import fls_pkg::*;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in                   i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out                  o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    failsafe_level_supervisor_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    typedef struct packed {
        logic       burner;
        logic [1:0] pumps;
        logic       relays;
        logic       save;
    } t_acts;

    // limits as the block should hold them
    logic [31:0] lim_delay;
    logic [7:0]  lim_attempts;
    logic [21:0] lim_crit;
    logic [21:0] lim_warn;
    logic [21:0] lim_clear;
    logic [31:0] lim_ivl;

    // supervisor state as the block should hold it
    logic [2:0]  st_level;
    logic [2:0]  st_reason;
    logic [31:0] st_first_ms;
    logic        st_first_seen;
    logic [7:0]  st_attempts;
    logic [31:0] st_ms;
    logic [31:0] st_check_ms;
    logic [4:0]  st_flags;

    t_out due_reports[$];
    int   items_sent   = 0;
    int   reports_seen = 0;
    int   errors       = 0;
    int   holdoff_left = 0;
    bit   steady       = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("failsafe_level_supervisor_top_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic void apply_actions(input logic [2:0] lv, inout t_acts a);
        if (lv >= LVL_CRITICAL) a.burner = 1'b1;
        if (lv >= LVL_EMERGENCY) a.pumps = PUMP_ON;
        case (lv)
            LVL_NORMAL: begin
                st_flags[ST_WARN] = 1'b0;
                st_flags[ST_BERR] = 1'b0;
            end
            LVL_EMERGENCY: begin
                st_level            = LVL_EMERGENCY;
                a.relays            = 1'b1;
                a.pumps             = PUMP_ON;
                st_flags[ST_ESTOP]  = 1'b1;
                st_flags[ST_BOILER] = 1'b0;
            end
            LVL_SHUTDOWN: begin
                st_level = LVL_SHUTDOWN;
                a.save   = 1'b1;
                a.pumps  = PUMP_OFF;
                a.relays = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic void raise_level(input logic [2:0] req, input logic [2:0] why,
                                        inout t_acts a);
        logic [2:0] lv;
        logic [2:0] prev;
        lv = (req > LVL_SHUTDOWN) ? LVL_SHUTDOWN : req;
        // at critical or above only a higher level gets through
        if (lv <= st_level && st_level >= LVL_CRITICAL) return;
        prev      = st_level;
        st_level  = lv;
        st_reason = why;
        if (!st_first_seen) begin
            st_first_seen = 1'b1;
            st_first_ms   = st_ms;
        end
        if (prev < LVL_CRITICAL && lv >= LVL_CRITICAL) a.save = 1'b1;
        apply_actions(lv, a);
        if (lv >= LVL_WARNING) st_flags[ST_BERR] = 1'b1;
        if (lv == LVL_WARNING) st_flags[ST_WARN] = 1'b1;
        else if (lv >= LVL_EMERGENCY) st_flags[ST_RSTOP] = 1'b1;
    endfunction

    function automatic logic try_recovery(input logic [21:0] heap, input logic sf,
                                          input logic mf);
        logic [31:0] elapsed;
        logic        cleared;
        if (st_level < LVL_CRITICAL) return 1'b1;
        if (st_attempts >= lim_attempts) return 1'b0;
        elapsed = st_ms - st_first_ms;
        if (elapsed < lim_delay) return 1'b0;
        // counted even when the root cause then blocks the recovery
        if (st_attempts != 8'hFF) st_attempts = st_attempts + 8'd1;
        cleared = 1'b1;
        if (st_reason == RSN_LOW_MEM && heap < lim_warn) cleared = 1'b0;
        if ((st_reason == RSN_SENS_READ || st_reason == RSN_SENS_DATA) && sf) cleared = 1'b0;
        if (st_reason == RSN_MODBUS && mf) cleared = 1'b0;
        if (!cleared) return 1'b0;
        st_flags[ST_WARN]   = 1'b0;
        st_flags[ST_BERR]   = 1'b0;
        st_flags[ST_ESTOP]  = 1'b0;
        st_flags[ST_BOILER] = 1'b1;
        st_level            = LVL_WARNING;
        return 1'b1;
    endfunction

    function automatic void run_health(input t_in it, inout t_acts a);
        logic [31:0] since;
        since = st_ms - st_check_ms;
        if (since < lim_ivl) return;
        st_check_ms = st_ms;
        if (it.free_heap < lim_crit) raise_level(LVL_CRITICAL, RSN_LOW_MEM, a);
        else if (it.free_heap < lim_warn) raise_level(LVL_WARNING, RSN_LOW_MEM, a);
        if (it.sensor_fault) raise_level(LVL_DEGRADED, RSN_SENS_READ, a);
        if (it.modbus_fault) raise_level(LVL_WARNING, RSN_MODBUS, a);
        if (st_level == LVL_WARNING && !it.sensor_fault && !it.modbus_fault &&
            !it.other_fault && it.free_heap > lim_clear) begin
            st_level = LVL_NORMAL;
            apply_actions(LVL_NORMAL, a);
        end
    endfunction

    function automatic t_out supervise(input t_in it);
        t_acts a;
        t_out  r;
        logic  rok;
        a   = '0;
        rok = 1'b0;
        case (it.kind)
            KIND_TICK:     st_ms = st_ms + 32'd1;
            KIND_TRIGGER:  raise_level(it.req_level, it.req_reason, a);
            KIND_RECOVERY: rok = try_recovery(it.free_heap, it.sensor_fault, it.modbus_fault);
            default:       run_health(it, a);
        endcase
        r.level               = st_level;
        r.burner_shutdown     = a.burner;
        r.pumps_cmd           = a.pumps;
        r.other_relays_off    = a.relays;
        r.save_request        = a.save;
        r.warning_flag        = st_flags[ST_WARN];
        r.burner_error_flag   = st_flags[ST_BERR];
        r.emergency_stop_flag = st_flags[ST_ESTOP];
        r.boiler_on_flag      = st_flags[ST_BOILER];
        r.relay_stop_flag     = st_flags[ST_RSTOP];
        r.recovery_ok         = rok;
        r.recovery_count      = st_attempts;
        return r;
    endfunction

    function automatic string describe(input t_out r);
        return $sformatf("lvl=%0d burn=%b pump=%0d relay=%b save=%b flags=%b%b%b%b%b rok=%b cnt=%0d",
                         r.level, r.burner_shutdown, r.pumps_cmd, r.other_relays_off,
                         r.save_request, r.warning_flag, r.burner_error_flag,
                         r.emergency_stop_flag, r.boiler_on_flag, r.relay_stop_flag,
                         r.recovery_ok, r.recovery_count);
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat: got %s", $realtime,
                         describe(o_out_data));
            end else begin
                want = due_reports.pop_front();
                if (o_out_data !== want) begin
                    errors++;
                    $display("%0t: result %0d mismatch: expected %s, got %s", $realtime,
                             reports_seen, describe(want), describe(o_out_data));
                end
            end
            reports_seen++;
        end
    end

    // result side stalls, plus the long hold-off when asked for
    initial begin : result_side
        int burst;
        burst = 0;
        forever begin
            @(negedge i_clk);
            if (holdoff_left > 0) begin
                holdoff_left--;
                i_out_stall <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (!steady && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 9);
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_item(input t_in it);
        int gap;
        if (!steady && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        due_reports.insert(due_reports.size(), supervise(it));
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_RECOVERY_DELAY: lim_delay    = val;
            CFG_MAX_ATTEMPTS:   lim_attempts = val[7:0];
            CFG_HEAP_CRITICAL:  lim_crit     = val[21:0];
            CFG_HEAP_WARNING:   lim_warn     = val[21:0];
            CFG_HEAP_CLEAR_MIN: lim_clear    = val[21:0];
            CFG_HEALTH_IVL:     lim_ivl      = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stop offering items and let every outstanding result drain
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_limits(input logic [31:0] delay, input logic [7:0] attempts,
                                  input logic [21:0] crit, input logic [21:0] warn,
                                  input logic [21:0] clear, input logic [31:0] ivl);
        write_reg(CFG_RECOVERY_DELAY, delay);
        write_reg(CFG_MAX_ATTEMPTS, {24'd0, attempts});
        write_reg(CFG_HEAP_CRITICAL, {10'd0, crit});
        write_reg(CFG_HEAP_WARNING, {10'd0, warn});
        write_reg(CFG_HEAP_CLEAR_MIN, {10'd0, clear});
        write_reg(CFG_HEALTH_IVL, ivl);
    endtask

    // ------------------------------------------------------------------
    // item makers
    // ------------------------------------------------------------------
    function automatic t_in make_item(input logic [1:0] kind, input logic [2:0] lv,
                                      input logic [2:0] why, input logic [21:0] heap,
                                      input logic sf, input logic mf, input logic of);
        t_in it;
        it.kind         = kind;
        it.req_level    = lv;
        it.req_reason   = why;
        it.free_heap    = heap;
        it.sensor_fault = sf;
        it.modbus_fault = mf;
        it.other_fault  = of;
        return it;
    endfunction

    // heap samples cluster around the thresholds in force
    function automatic logic [21:0] pick_heap();
        logic [21:0] near;
        case ($urandom_range(0, 7))
            0: return 22'd0;
            1: return 22'h3FFFFF;
            2: return 22'($urandom);
            default: begin
                case ($urandom_range(0, 2))
                    0:       near = lim_crit;
                    1:       near = lim_warn;
                    default: near = lim_clear;
                endcase
                return near + 22'($urandom_range(0, 2)) - 22'd1;
            end
        endcase
    endfunction

    function automatic logic pick_fault();
        return ($urandom_range(0, 3) == 0);
    endfunction

    function automatic t_in noise_item();
        return make_item(2'($urandom), 3'($urandom), 3'($urandom), pick_heap(),
                         1'($urandom), 1'($urandom), 1'($urandom));
    endfunction

    // one incident (trigger, time passing, maybe a health check, recovery) or a burst of noise items
    task automatic run_episode();
        logic [2:0] lv;
        if ($urandom_range(0, 9) < 3) begin
            repeat ($urandom_range(1, 4)) send_item(noise_item());
        end else begin
            lv = ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'($urandom_range(1, 5));
            send_item(make_item(KIND_TRIGGER, lv, 3'($urandom), pick_heap(),
                                1'($urandom), 1'($urandom), 1'($urandom)));
            repeat ($urandom_range(0, 6))
                send_item(make_item(KIND_TICK, 3'($urandom), 3'($urandom), pick_heap(),
                                    1'($urandom), 1'($urandom), 1'($urandom)));
            if ($urandom_range(0, 1))
                send_item(make_item(KIND_HEALTH, 3'($urandom), 3'($urandom), pick_heap(),
                                    pick_fault(), pick_fault(), pick_fault()));
            repeat ($urandom_range(1, 2))
                send_item(make_item(KIND_RECOVERY, 3'($urandom), 3'($urandom), pick_heap(),
                                    pick_fault(), pick_fault(), 1'($urandom)));
            if ($urandom_range(0, 2) == 0)
                send_item(make_item(KIND_HEALTH, 3'($urandom), 3'($urandom), pick_heap(),
                                    pick_fault(), pick_fault(), pick_fault()));
        end
    endtask

    task automatic random_limits();
        logic [21:0] crit;
        logic [21:0] warn;
        crit = 22'($urandom_range(0, 4000));
        warn = crit + 22'($urandom_range(0, 4000));
        program_limits($urandom_range(0, 40),
                       ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 8)),
                       crit, warn, warn + 22'($urandom_range(0, 4000)),
                       $urandom_range(0, 6));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        send_item(make_item(KIND_TRIGGER, LVL_DEGRADED, RSN_SENS_DATA, 22'd0,
                            1'b0, 1'b0, 1'b0));
        // below critical a recovery passes without touching anything
        send_item(make_item(KIND_RECOVERY, LVL_NORMAL, RSN_NONE, 22'd0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_TRIGGER, LVL_EMERGENCY, RSN_MODBUS, 22'd0,
                            1'b0, 1'b0, 1'b0));
        // default delay not yet elapsed
        send_item(make_item(KIND_RECOVERY, LVL_NORMAL, RSN_NONE, 22'h3FFFFF,
                            1'b0, 1'b0, 1'b0));
        // default interval not yet elapsed, check skipped
        send_item(make_item(KIND_HEALTH, LVL_NORMAL, RSN_NONE, 22'd0, 1'b1, 1'b1, 1'b1));
        send_item(make_item(KIND_TICK, LVL_NORMAL, RSN_NONE, 22'd0, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_levels_and_recovery();
        settle();
        program_limits(32'd0, 8'd3, 22'd100, 22'd200, 22'd300, 32'd0);
        // out-of-range level and reason: shutdown, no root-cause check
        send_item(make_item(KIND_TRIGGER, 3'd7, 3'd7, 22'd0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_RECOVERY, LVL_NORMAL, RSN_NONE, 22'h3FFFFF,
                            1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_TRIGGER, LVL_CRITICAL, RSN_LOW_MEM, 22'd0,
                            1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_RECOVERY, LVL_NORMAL, RSN_NONE, 22'd0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_RECOVERY, LVL_NORMAL, RSN_NONE, 22'h3FFFFF,
                            1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_TRIGGER, 3'd6, RSN_SENS_READ, 22'd0, 1'b0, 1'b0, 1'b0));
        // attempt limit reached
        send_item(make_item(KIND_RECOVERY, LVL_NORMAL, RSN_NONE, 22'h3FFFFF,
                            1'b1, 1'b0, 1'b0));
        settle();
        write_reg(CFG_MAX_ATTEMPTS, 32'd255);
        send_item(make_item(KIND_RECOVERY, LVL_NORMAL, RSN_NONE, 22'h3FFFFF,
                            1'b1, 1'b0, 1'b0));
        send_item(make_item(KIND_RECOVERY, LVL_NORMAL, RSN_NONE, 22'h3FFFFF,
                            1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_TRIGGER, LVL_EMERGENCY, RSN_MODBUS, 22'd0,
                            1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_RECOVERY, LVL_NORMAL, RSN_NONE, 22'h3FFFFF,
                            1'b0, 1'b1, 1'b0));
        send_item(make_item(KIND_RECOVERY, LVL_NORMAL, RSN_NONE, 22'h3FFFFF,
                            1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_TRIGGER, LVL_DEGRADED, RSN_SENS_DATA, 22'd0,
                            1'b0, 1'b0, 1'b0));
        // several triggers in one health check; the later ones are ignored
        send_item(make_item(KIND_HEALTH, LVL_NORMAL, RSN_NONE, 22'd0, 1'b1, 1'b1, 1'b0));
        send_item(make_item(KIND_TRIGGER, LVL_NORMAL, RSN_NONE, 22'd0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_RECOVERY, LVL_NORMAL, RSN_NONE, 22'd250,
                            1'b0, 1'b0, 1'b0));
        // all well: warning clears back to normal
        send_item(make_item(KIND_HEALTH, LVL_NORMAL, RSN_NONE, 22'h3FFFFF,
                            1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_HEALTH, LVL_NORMAL, RSN_NONE, 22'd150, 1'b0, 1'b1, 1'b0));
        send_item(make_item(KIND_HEALTH, LVL_NORMAL, RSN_NONE, 22'h3FFFFF,
                            1'b1, 1'b0, 1'b0));
        send_item(make_item(KIND_TRIGGER, LVL_NORMAL, RSN_OTHER, 22'd0, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_backpressure();
        settle();
        random_limits();
        @(posedge i_clk);
        holdoff_left = 60;
        repeat (30) send_item(noise_item());
    endtask

    task automatic test_random_phases();
        int goal;
        for (int p = 0; p < 6; p++) begin
            settle();
            case (p)
                0: program_limits(32'hFFFF_FFFF, 8'd0, 22'd0, 22'd0, 22'd0, 32'hFFFF_FFFF);
                1: program_limits(32'd0, 8'hFF, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, 32'd0);
                // thresholds in no particular order
                5: program_limits($urandom_range(0, 20), 8'($urandom_range(1, 8)),
                                  22'($urandom_range(0, 5000)), 22'($urandom_range(0, 5000)),
                                  22'($urandom_range(0, 5000)), $urandom_range(0, 4));
                default: random_limits();
            endcase
            goal = items_sent + 170;
            while (items_sent < goal) run_episode();
        end
    endtask

    task automatic test_steady_stream();
        int goal;
        settle();
        random_limits();
        @(posedge i_clk);
        steady = 1'b1;
        goal = items_sent + 120;
        while (items_sent < goal) run_episode();
    endtask

    initial begin
        lim_delay     = 32'd30000;
        lim_attempts  = 8'd3;
        lim_crit      = 22'd10000;
        lim_warn      = 22'd20000;
        lim_clear     = 22'd30000;
        lim_ivl       = 32'd5000;
        st_level      = LVL_NORMAL;
        st_reason     = RSN_NONE;
        st_first_ms   = '0;
        st_first_seen = 1'b0;
        st_attempts   = '0;
        st_ms         = '0;
        st_check_ms   = '0;
        st_flags      = '0;
        st_flags[ST_BOILER] = 1'b1;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_levels_and_recovery();
        test_backpressure();
        test_random_phases();
        test_steady_stream();

        settle();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("failsafe_level_supervisor_top_tb: PASS");
        end else begin
            $display("failsafe_level_supervisor_top_tb: FAIL");
        end
        $finish;
    end

endmodule
